// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Check that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

// File: src/gtpf_pkg.sv
// ----------------------------------------------------------------------------
// gtpf_pkg
// Shared types and codes of the group test positive finder.
// ----------------------------------------------------------------------------
`default_nettype none

package gtpf_pkg;

    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam logic [CNT_W-1:0] MAX_ITEMS = 11'd1024;

    localparam logic [1:0] KIND_QUERY = 2'd0;
    localparam logic [1:0] KIND_FOUND = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    localparam logic OP_START  = 1'b0;
    localparam logic OP_ANSWER = 1'b1;

    localparam logic REG_NUM_ITEMS  = 1'b0;
    localparam logic REG_GROUP_SIZE = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_BLOCK = 3'b010,
        PH_SPLIT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [IDX_W-1:0] range_low;
        logic [CNT_W-1:0] range_high;
        logic             last_of_run;
    } result_t;

endpackage

`default_nettype wire

// File: src/group_test_positive_finder_unit.sv
// ----------------------------------------------------------------------------
// group_test_positive_finder_unit
// Binary-splitting group test sequencer over a row of up to 1024 items.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): opcode start launches a scan at item
//   0; opcode answer carries pool_positive for the last pool query issued.
//   Output channel (out_valid / out_stall): each beat is a pool query, a found
//   item or a done marker; last_of_run flags the final beat of one input.
//   Each input yields zero, one or two result beats.
//   Config port (cfg_we / cfg_index / cfg_data): index 0 num_items, index 1
//   group_size; write only while the block is idle.
// Timing:
//   An accepted input is decoded in the same cycle against the search state;
//   its results land in a four-entry result queue, and the output shows the
//   oldest queued result. One input is taken per cycle as long as the
//   queue has two free slots; in_stall rises when more than two results wait.
// Reset:
//   Phase goes idle, num_items = 1024, group_size = 1, queue empty.
// Stall:
//   A stalled output beat holds; further inputs are taken until the queue
//   runs short of room for two more results.
// ----------------------------------------------------------------------------
`default_nettype none

module group_test_positive_finder_unit (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic                    opcode,
    input  wire logic                    pool_positive,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [1:0]                   kind,
    output logic [gtpf_pkg::IDX_W-1:0]   range_low,
    output logic [gtpf_pkg::CNT_W-1:0]   range_high,
    output logic                         last_of_run,
    input  wire logic                    cfg_we,
    input  wire logic                    cfg_index,
    input  wire logic [gtpf_pkg::CNT_W-1:0] cfg_data
);
    import gtpf_pkg::*;

    // Configuration registers
    logic [CNT_W-1:0] num_items_reg;
    logic [CNT_W-1:0] group_size_reg;

    // Search state
    phase_t           phase_reg, phase_next;
    logic [IDX_W-1:0] sl_reg, sl_next;
    logic [CNT_W-1:0] sh_reg, sh_next;

    // Result queue
    result_t          fifo_reg [4];
    logic [1:0]       wr_ptr_reg, rd_ptr_reg;
    logic [2:0]       count_reg;

    logic             in_accept, out_pop;
    result_t          res0, res1;
    logic [1:0]       nres;

    // Decode datapath
    logic [CNT_W-1:0] n_eff;
    logic [IDX_W+1:0] cur_sum, nar_sum;
    logic [CNT_W-1:0] cur_mid, nar_mid;
    logic [IDX_W-1:0] nl;
    logic [CNT_W-1:0] nh;
    logic             split_ok;
    logic [CNT_W-1:0] nb_pos, nb_rem, nb_len, nb_hi;
    logic             nb_done;
    result_t          nb_res;
    logic             take_nb, take_narrow;

    assign in_stall  = (count_reg > 3'd2);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != 3'd0);
    assign out_pop   = out_valid && !out_stall;

    assign kind        = fifo_reg[rd_ptr_reg].kind;
    assign range_low   = fifo_reg[rd_ptr_reg].range_low;
    assign range_high  = fifo_reg[rd_ptr_reg].range_high;
    assign last_of_run = fifo_reg[rd_ptr_reg].last_of_run;

    always_comb
    begin
        // Clamp the item count to the row length
        n_eff = (num_items_reg > MAX_ITEMS) ? MAX_ITEMS : num_items_reg;

        // Midpoint of the range held in state
        cur_sum = {2'b00, sl_reg} + {1'b0, sh_reg};
        cur_mid = cur_sum[CNT_W:1];

        // Range to narrow: split answers move one bound to the midpoint
        nl = sl_reg;
        nh = sh_reg;
        if (phase_reg == PH_SPLIT)
        begin
            if (pool_positive)
                nh = cur_mid;
            else
                nl = cur_mid[IDX_W-1:0];
        end
        split_ok = (({1'b0, nl} + 11'd1) < nh);
        nar_sum  = {2'b00, nl} + {1'b0, nh};
        nar_mid  = nar_sum[CNT_W:1];

        // Which first-level pool start applies to this input
        if (opcode == OP_START)
            nb_pos = '0;
        else if (phase_reg == PH_BLOCK && !pool_positive)
            nb_pos = sh_reg;
        else
            nb_pos = {1'b0, nl} + 11'd1;

        nb_done = (group_size_reg == '0) || (nb_pos >= n_eff);
        nb_rem  = n_eff - nb_pos;
        nb_len  = (group_size_reg < nb_rem) ? group_size_reg : nb_rem;
        nb_hi   = nb_pos + nb_len;
        if (nb_done)
            nb_res = '{kind: KIND_DONE, range_low: '0, range_high: '0, last_of_run: 1'b0};
        else
            nb_res = '{kind: KIND_QUERY, range_low: nb_pos[IDX_W-1:0],
                       range_high: nb_hi, last_of_run: 1'b0};

        take_nb     = 1'b0;
        take_narrow = 1'b0;
        if (opcode == OP_START)
            take_nb = 1'b1;
        else
        begin
            case (phase_reg)
                PH_BLOCK:
                begin
                    if (pool_positive)
                        take_narrow = 1'b1;
                    else
                        take_nb = 1'b1;
                end
                PH_SPLIT: take_narrow = 1'b1;
                default:  ;
            endcase
        end

        phase_next = phase_reg;
        sl_next    = sl_reg;
        sh_next    = sh_reg;
        res0       = '0;
        res1       = '0;
        nres       = 2'd0;

        if (take_nb)
        begin
            res0 = nb_res;
            nres = 2'd1;
        end
        else if (take_narrow)
        begin
            sl_next = nl;
            sh_next = nh;
            if (split_ok)
            begin
                // Query the lower half
                res0 = '{kind: KIND_QUERY, range_low: nl, range_high: nar_mid,
                         last_of_run: 1'b0};
                phase_next = PH_SPLIT;
                nres = 2'd1;
            end
            else
            begin
                // Single item left: report it, then form the next pool
                res0 = '{kind: KIND_FOUND, range_low: nl, range_high: '0,
                         last_of_run: 1'b0};
                res1 = nb_res;
                nres = 2'd2;
            end
        end

        if (take_nb || (take_narrow && !split_ok))
        begin
            if (nb_done)
                phase_next = PH_IDLE;
            else
            begin
                phase_next = PH_BLOCK;
                sl_next    = nb_pos[IDX_W-1:0];
                sh_next    = nb_hi;
            end
        end

        // Flag the final beat of this input
        if (nres == 2'd2)
            res1.last_of_run = 1'b1;
        else
            res0.last_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_items_reg  <= MAX_ITEMS;
            group_size_reg <= 11'd1;
            phase_reg      <= PH_IDLE;
            sl_reg         <= '0;
            sh_reg         <= '0;
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NUM_ITEMS:  num_items_reg  <= cfg_data;
                    REG_GROUP_SIZE: group_size_reg <= cfg_data;
                    default:        ;
                endcase
            end
            if (in_accept)
            begin
                phase_reg  <= phase_next;
                sl_reg     <= sl_next;
                sh_reg     <= sh_next;
                wr_ptr_reg <= wr_ptr_reg + nres;
            end
            if (out_pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_reg + (in_accept ? {1'b0, nres} : 3'd0)
                         - (out_pop ? 3'd1 : 3'd0);
        end
    end

    // Queue payload: push up to two results per accepted input
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            if (nres != 2'd0)
                fifo_reg[wr_ptr_reg] <= res0;
            if (nres == 2'd2)
                fifo_reg[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

`default_nettype wire

// File: src/gtpf_checker.sv
// ----------------------------------------------------------------------------
// gtpf_checker
// Port-level checks on the result channel of the finder.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module gtpf_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       out_valid,
    input wire logic                       out_stall,
    input wire logic [1:0]                 kind,
    input wire logic [gtpf_pkg::IDX_W-1:0] range_low,
    input wire logic [gtpf_pkg::CNT_W-1:0] range_high,
    input wire logic                       last_of_run
);
    import gtpf_pkg::*;

    logic             kind_ok;
    logic             is_query;
    logic [CNT_W-1:0] low_ext;
    result_t          out_beat;

    assign kind_ok  = (kind == KIND_QUERY) || (kind == KIND_FOUND) || (kind == KIND_DONE);
    assign is_query = out_valid && (kind == KIND_QUERY);
    assign low_ext  = {1'b0, range_low};
    assign out_beat = {kind, range_low, range_high, last_of_run};

    // Hold a stalled result beat
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    // A stalled result beat keeps its payload
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_beat))
    // Only defined result codes leave the block
    `ASSERT_SAME(a_kind_legal, clk, rst_n, out_valid, kind_ok)
    // Found and done beats carry no upper bound
    `ASSERT_SAME(a_no_high, clk, rst_n, out_valid && kind != KIND_QUERY, range_high == '0)
    // A queried pool is never empty
    `ASSERT_SAME(a_query_nonempty, clk, rst_n, is_query, range_high > low_ext)

endmodule

bind group_test_positive_finder_unit gtpf_checker u_gtpf_checker (.*);

`default_nettype wire

// File: tb/group_test_positive_finder_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// group_test_positive_finder_unit_tb
// Self-checking bench for the binary-splitting group test sequencer.
// ----------------------------------------------------------------------------
// A short directed run walks the corner cases: answers while idle, group and
// item counts of zero, restarts, a register change in the middle of a scan,
// and the widest pools and highest indexes. Random scans then follow with
// random answers under four idle/stall mixes. A tracker object predicts every
// result beat from its own copy of the search state. The output monitor
// checks each beat, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------

module group_test_positive_finder_unit_tb;

    import gtpf_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned TARGET_BEATS = 1150;
    localparam int unsigned SETTLE_CYCLES = 4;

    // ------------------------------------------------------------------------
    // Search tracker: mirrors the scan state and queues the predicted beats.
    // ------------------------------------------------------------------------
    class split_search_tracker;
        int unsigned row_len;
        int unsigned pool_len;
        int unsigned block_start;
        int unsigned search_low;
        int unsigned search_high;
        phase_t      stage;
        result_t     pending[$];
        int unsigned faults;
        int unsigned requests;
        int unsigned starts;
        int unsigned reports;
        int unsigned found_count;
        int unsigned done_count;

        function new();
            row_len = 32'(MAX_ITEMS);
            pool_len = 1;
            block_start = 0;
            search_low = 0;
            search_high = 0;
            stage = PH_IDLE;
            faults = 0;
            requests = 0;
            starts = 0;
            reports = 0;
            found_count = 0;
            done_count = 0;
        endfunction

        function int unsigned item_limit();
            return (row_len > 32'(MAX_ITEMS)) ? 32'(MAX_ITEMS) : row_len;
        endfunction

        function bit scanning();
            return stage != PH_IDLE;
        endfunction

        function void write_reg(logic idx, logic [CNT_W-1:0] val);
            if (idx == REG_NUM_ITEMS)
                row_len = 32'(val);
            else
                pool_len = 32'(val);
        endfunction

        function void post(logic [1:0] k, int unsigned lo, int unsigned hi);
            result_t r;
            r.kind = k;
            r.range_low = lo[IDX_W-1:0];
            r.range_high = hi[CNT_W-1:0];
            r.last_of_run = 1'b0;
            pending.push_back(r);
        endfunction

        // Form the first-level pool at the given index, or close the scan.
        function void open_pool(int unsigned at);
            int unsigned n;
            int unsigned len;
            n = item_limit();
            if (pool_len == 0 || at >= n)
            begin
                stage = PH_IDLE;
                post(KIND_DONE, 0, 0);
            end
            else
            begin
                len = n - at;
                if (pool_len < len)
                    len = pool_len;
                block_start = at;
                search_low = at;
                search_high = at + len;
                stage = PH_BLOCK;
                post(KIND_QUERY, at, at + len);
            end
        endfunction

        // Query the lower half, or report the lone item and move on.
        function void narrow_down();
            if (search_low + 1 < search_high)
            begin
                stage = PH_SPLIT;
                post(KIND_QUERY, search_low, (search_low + search_high) >> 1);
            end
            else
            begin
                post(KIND_FOUND, search_low, 0);
                open_pool(search_low + 1);
            end
        endfunction

        // Note an accepted input beat; return 0 when the block ignores it.
        function bit take_request(logic op, logic pp);
            int unsigned mark;
            int unsigned mid;
            mark = pending.size();
            if (op == OP_START)
            begin
                starts++;
                open_pool(0);
            end
            else if (stage == PH_BLOCK)
            begin
                if (pp)
                    narrow_down();
                else
                    open_pool(search_high);
            end
            else if (stage == PH_SPLIT)
            begin
                mid = (search_low + search_high) >> 1;
                if (pp)
                    search_high = mid;
                else
                    search_low = mid;
                narrow_down();
            end
            else
                return 1'b0;
            if (pending.size() > mark)
                pending[pending.size() - 1].last_of_run = 1'b1;
            requests++;
            return 1'b1;
        endfunction

        function void note_fault(string msg);
            faults++;
            if (faults <= 10)
                $display("ERROR: %s", msg);
        endfunction

        function void match_report(result_t got);
            result_t want;
            reports++;
            if (pending.size() == 0)
            begin
                note_fault($sformatf("beat %0d unexpected: kind=%0d low=%0d high=%0d last=%0b",
                    reports, got.kind, got.range_low, got.range_high, got.last_of_run));
                return;
            end
            want = pending.pop_front();
            if (want.kind == KIND_FOUND)
                found_count++;
            if (want.kind == KIND_DONE)
                done_count++;
            if (got.kind !== want.kind || got.range_low !== want.range_low ||
                got.range_high !== want.range_high || got.last_of_run !== want.last_of_run)
                note_fault($sformatf({"beat %0d: want kind=%0d low=%0d high=%0d last=%0b, ",
                    "got kind=%0d low=%0d high=%0d last=%0b"}, reports,
                    want.kind, want.range_low, want.range_high, want.last_of_run,
                    got.kind, got.range_low, got.range_high, got.last_of_run));
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block hookup; every input starts at a known value.
    // ------------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             opcode = OP_START;
    logic             pool_positive = 1'b0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [1:0]       kind;
    logic [IDX_W-1:0] range_low;
    logic [CNT_W-1:0] range_high;
    logic             last_of_run;
    logic             cfg_we = 1'b0;
    logic             cfg_index = REG_NUM_ITEMS;
    logic [CNT_W-1:0] cfg_data = '0;

    group_test_positive_finder_unit DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .pool_positive (pool_positive),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .kind          (kind),
        .range_low     (range_low),
        .range_high    (range_high),
        .last_of_run   (last_of_run),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    split_search_tracker tracker = new();

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned work_beats = 0;
    int unsigned cycle_count = 0;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up once the run has clearly hung.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("group_test_positive_finder_unit: mismatch");
            $finish;
        end
    end

    // Output side: check each accepted result beat, then pick the next stall.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                tracker.match_report('{kind, range_low, range_high, last_of_run});
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Drive tasks
    // ------------------------------------------------------------------------

    // Offer one input beat after a random idle stretch; return once accepted.
    task automatic send_beat(input logic op, input logic pp);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            opcode <= 1'($urandom);
            pool_positive <= 1'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        pool_positive <= pp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tracker.take_request(op, pp))
            work_beats++;
    endtask

    // Drop valid and hold off until every predicted beat is out.
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; call only while the block is drained.
    task automatic program_reg(input logic idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val[CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(idx, val[CNT_W-1:0]);
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned n_sel;
        int unsigned g_sel;
        int unsigned pos_pct;
        int unsigned scans;
        int unsigned pick;
        int unsigned phase_goal;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Answers while idle must be ignored (reset defaults still apply).
        send_beat(OP_ANSWER, 1'b1);
        send_beat(OP_ANSWER, 1'b0);
        settle();

        // Pool wider than the row: split down to items 1 and 2, the last
        // lone-item pool gives found and done from one answer.
        program_reg(REG_NUM_ITEMS, 3);
        program_reg(REG_GROUP_SIZE, 4);
        send_beat(OP_START, 1'b0);
        send_beat(OP_ANSWER, 1'b1);
        send_beat(OP_ANSWER, 1'b0);
        send_beat(OP_ANSWER, 1'b1);
        send_beat(OP_ANSWER, 1'b1);
        settle();

        // Zero group size and zero item count both end the scan at once.
        program_reg(REG_GROUP_SIZE, 0);
        send_beat(OP_START, 1'b1);
        settle();
        program_reg(REG_GROUP_SIZE, 5);
        program_reg(REG_NUM_ITEMS, 0);
        send_beat(OP_START, 1'b0);
        settle();

        // Restart during a scan, then change the group size mid-scan.
        program_reg(REG_NUM_ITEMS, 10);
        send_beat(OP_START, 1'b0);
        send_beat(OP_START, 1'b0);
        settle();
        program_reg(REG_GROUP_SIZE, 1);
        send_beat(OP_ANSWER, 1'b0);
        send_beat(OP_ANSWER, 1'b1);
        settle();

        // Oversized item count clamps to the full row; chase the top item.
        program_reg(REG_NUM_ITEMS, 2047);
        program_reg(REG_GROUP_SIZE, 1024);
        send_beat(OP_START, 1'b0);
        send_beat(OP_ANSWER, 1'b1);
        while (tracker.scanning())
            send_beat(OP_ANSWER, 1'b0);
        settle();

        // Random scans under four idle/stall mixes.
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 65;
                    stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 65;
                end
                default:
                begin
                    send_idle_pct = 22;
                    stall_pct = 22;
                end
            endcase
            phase_goal = (TARGET_BEATS * (p + 1)) / 4;
            while (work_beats < phase_goal)
            begin
                settle();
                // Pick a row and pool size: mostly short rows, a few extremes.
                pick = $urandom_range(99);
                if (pick < 80)
                begin
                    n_sel = $urandom_range(1, 48);
                    g_sel = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, n_sel + 4);
                end
                else if (pick < 90)
                begin
                    n_sel = $urandom_range(49, 300);
                    g_sel = $urandom_range(n_sel / 8 + 1, n_sel + 10);
                end
                else
                begin
                    case ($urandom_range(3))
                        0: n_sel = 0;
                        1: n_sel = 1;
                        2: n_sel = 1024;
                        default: n_sel = 2047;
                    endcase
                    case ($urandom_range(3))
                        0: g_sel = 0;
                        1: g_sel = 64;
                        2: g_sel = 1024;
                        default: g_sel = 2047;
                    endcase
                end
                if ($urandom_range(1))
                begin
                    program_reg(REG_NUM_ITEMS, n_sel);
                    program_reg(REG_GROUP_SIZE, g_sel);
                end
                else
                begin
                    program_reg(REG_GROUP_SIZE, g_sel);
                    program_reg(REG_NUM_ITEMS, n_sel);
                end

                // Noise: a burst of random opcodes with no regard to the scan.
                if ($urandom_range(99) < 8)
                begin
                    repeat ($urandom_range(3, 10))
                        send_beat(($urandom_range(99) < 25) ? OP_START : OP_ANSWER,
                            1'($urandom_range(1)));
                    continue;
                end

                scans = $urandom_range(1, 3);
                repeat (scans)
                begin
                    pos_pct = (tracker.item_limit() > 300) ? $urandom_range(0, 10)
                                                            : $urandom_range(0, 60);
                    send_beat(OP_START, 1'($urandom_range(1)));
                    while (tracker.scanning())
                    begin
                        pick = $urandom_range(99);
                        if (pick < 2)
                            send_beat(OP_START, 1'($urandom_range(1)));
                        else if (pick < 5)
                        begin
                            // Hold the sender until the block drains, and now
                            // and then move the pool size under the scan.
                            settle();
                            if (tracker.item_limit() <= 48 && $urandom_range(1))
                                program_reg(REG_GROUP_SIZE, $urandom_range(1, 8));
                        end
                        else
                            send_beat(OP_ANSWER, $urandom_range(99) < pos_pct);
                    end
                    // Stray answer after the scan closed.
                    if ($urandom_range(99) < 20)
                        send_beat(OP_ANSWER, 1'($urandom_range(1)));
                end
            end
        end

        // Drain and leave room for anything extra to show up.
        send_idle_pct = 0;
        stall_pct = 0;
        settle();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("run covered %0d input beats (%0d scan starts) in %0d cycles",
            tracker.requests, tracker.starts, cycle_count);
        $display("checked %0d result beats: %0d positives found, %0d scans closed",
            tracker.reports, tracker.found_count, tracker.done_count);
        if (tracker.faults == 0 && tracker.pending.size() == 0)
            $display("group_test_positive_finder_unit: match");
        else
            $display("group_test_positive_finder_unit: mismatch");
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/gtpf_pkg.sv
src/group_test_positive_finder_unit.sv
src/gtpf_checker.sv
tb/group_test_positive_finder_unit_tb.sv
